>>> rtl/core/key_debounce_click_hold_detector_defines.svh
// Assertion macros shared by the key debounce checker.
`ifndef KEY_DEBOUNCE_CLICK_HOLD_DETECTOR_DEFINES_SVH
`define KEY_DEBOUNCE_CLICK_HOLD_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define KDCH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define KDCH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/kdch_pkg.sv
// Shared constants and types of the key debounce, click and hold detector.
package kdch_pkg;

	// fixed field widths
	localparam int KEY_PINS  = 3;
	localparam int KEY_W     = 2;
	localparam int KIND_W    = 3;
	localparam int STAMP_W   = 16;
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 2;
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 24;

	// event buffer for one tick
	localparam int MAX_EVENTS = 4;
	localparam int EV_CNT_W   = 3;

	// click tally
	localparam logic [1:0] MULTI_CLICK = 2'd2;
	localparam logic [1:0] TALLY_MAX   = 2'd3;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_CLICK    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DOUBLE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TRIPLE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HOLDING  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd4;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_HOLD_THRESHOLD = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLICK_WINDOW   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEYS_IN_USE    = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] HOLD_THRESHOLD_RST = 16'd100;
	localparam logic [CFG_W-1:0] CLICK_WINDOW_RST   = 16'd30;
	localparam logic [1:0]       KEYS_IN_USE_RST    = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
	} event_t;

endpackage

>>> rtl/core/key_debounce_click_hold_detector.sv
// Key debounce with click, multi-click and long-press detection, one shared counter unit.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tdata: key_levels; tuser: pin_changed
//  m_      | out       | m_tvalid/m_tready  | tdata: key_index, tick_stamp; tuser: kind
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_addr: register index; cfg_data: value
//
// A tick runs through accept, timer, click check, a hold pass over the scanned keys
// when any key is held, change check and, when the keys settled on a new pattern, a
// change pass over the scanned keys, then a drain that sends each event it caused;
// the shared saturating incrementer and comparators walk the keys. s_tready is high
// only between ticks.
// Reset clears all counters and flags; s_tready is high from reset on, as reset selects the idle state.
// A stalled m_ side holds the event in its output register and the drain waits.
module key_debounce_click_hold_detector #(
	parameter int NUM_KEYS   = 3,
	parameter int COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_tdata: [2:0] key_levels, [7:3] zero
	input  logic [kdch_pkg::S_TDATA_W-1:0]       s_tdata,
	// s_tuser: [0] pin_changed
	input  logic                                 s_tuser,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// m_tdata: [1:0] key_index, [17:2] tick_stamp, [23:18] zero
	output logic [kdch_pkg::M_TDATA_W-1:0]       m_tdata,
	// m_tuser: [2:0] event_kind
	output logic [kdch_pkg::KIND_W-1:0]          m_tuser,
	output logic                                 m_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kdch_pkg::REG_IDX_W-1:0]       cfg_addr,
	input  logic [kdch_pkg::CFG_W-1:0]           cfg_data
);

	localparam int SLOTS = (NUM_KEYS < kdch_pkg::KEY_PINS) ? NUM_KEYS : kdch_pkg::KEY_PINS;
	localparam logic [1:0] SCAN_CAP = 2'(SLOTS);
	localparam int CMP_W = (COUNT_BITS > kdch_pkg::CFG_W) ? COUNT_BITS : kdch_pkg::CFG_W;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam int PAD_W = kdch_pkg::M_TDATA_W - kdch_pkg::KEY_W - kdch_pkg::STAMP_W;
	localparam int EV_W = kdch_pkg::EV_CNT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_TIMER  = 3'd1;
	localparam logic [2:0] ST_CLICK  = 3'd2;
	localparam logic [2:0] ST_HOLD   = 3'd3;
	localparam logic [2:0] ST_CHANGE = 3'd4;
	localparam logic [2:0] ST_KEYS   = 3'd5;
	localparam logic [2:0] ST_DRAIN  = 3'd6;

	logic [2:0]                       state_q;
	logic [1:0]                       k_q;
	logic [1:0]                       drain_q;
	logic [kdch_pkg::EV_CNT_W-1:0]    ev_cnt_q;
	logic [COUNT_BITS-1:0]            tick_q;
	logic [COUNT_BITS-1:0]            timer_q;
	logic [1:0]                       tally_q;
	logic [kdch_pkg::KEY_W-1:0]       click_key_q;
	logic [COUNT_BITS-1:0]            hold_q [SLOTS];
	logic                             any_held_q;
	logic                             change_q;
	logic [kdch_pkg::KEY_PINS-1:0]    prev_q;
	logic [kdch_pkg::KEY_PINS-1:0]    rep_q;
	logic [kdch_pkg::CFG_W-1:0]       thr_q;
	logic [kdch_pkg::CFG_W-1:0]       win_q;
	logic [1:0]                       kiu_q;
	logic                             m_valid_q;

	logic [kdch_pkg::KEY_PINS-1:0]    sample_q;
	logic [kdch_pkg::KEY_PINS-1:0]    diff_q;
	kdch_pkg::event_t                 ev_q [kdch_pkg::MAX_EVENTS];
	logic [kdch_pkg::KIND_W-1:0]      m_kind_q;
	logic [kdch_pkg::KEY_W-1:0]       m_key_q;
	logic [kdch_pkg::STAMP_W-1:0]     m_stamp_q;
	logic                             m_last_q;

	logic [1:0]                       scan;
	logic [1:0]                       k_next;
	logic                             k_last;
	logic [COUNT_BITS-1:0]            hold_sel;
	logic [COUNT_BITS-1:0]            op_a;
	logic [kdch_pkg::CFG_W-1:0]       op_b;
	logic [COUNT_BITS-1:0]            unit_inc;
	logic                             unit_gt;
	logic                             unit_eq;
	logic [CMP_W-1:0]                 tick_ext;
	logic                             push_en;
	kdch_pkg::event_t                 push_ev;
	logic                             hold_we;
	logic [COUNT_BITS-1:0]            hold_wd;
	logic                             out_load;
	logic [kdch_pkg::EV_CNT_W-1:0]    drain_next;
	logic                             drain_last;
	logic                             key_level;
	logic [kdch_pkg::KIND_W-1:0]      click_kind;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = m_kind_q;
	assign m_tlast   = m_last_q;
	assign m_tdata   = {{PAD_W{1'b0}}, m_stamp_q, m_key_q};

	assign scan     = (kiu_q < SCAN_CAP) ? kiu_q : SCAN_CAP;
	assign k_next   = k_q + 2'd1;
	assign k_last   = (k_next == scan);
	assign tick_ext = CMP_W'(tick_q);
	assign key_level = sample_q[k_q];

	always_comb begin
		hold_sel = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (k_q == 2'(i)) begin
				hold_sel = hold_q[i];
			end
		end
	end

	// shared unit: saturating increment, compare of the increment for equality,
	// compare of the operand for greater-than
	always_comb begin
		case (state_q)
			ST_TIMER, ST_CLICK: op_a = timer_q;
			default:            op_a = hold_sel;
		endcase
		op_b     = (state_q == ST_CLICK) ? win_q : thr_q;
		unit_inc = (op_a == CNT_MAX) ? op_a : op_a + COUNT_BITS'(1);
		unit_gt  = CMP_W'(op_a) > CMP_W'(op_b);
		unit_eq  = CMP_W'(unit_inc) == CMP_W'(op_b);
	end

	always_comb begin
		if (tally_q == kdch_pkg::TALLY_MAX) begin
			click_kind = kdch_pkg::KIND_TRIPLE;
		end else if (tally_q == kdch_pkg::MULTI_CLICK) begin
			click_kind = kdch_pkg::KIND_DOUBLE;
		end else begin
			click_kind = kdch_pkg::KIND_CLICK;
		end
	end

	always_comb begin
		push_en      = 1'b0;
		push_ev.kind = kdch_pkg::KIND_CLICK;
		push_ev.key  = k_q;
		hold_we      = 1'b0;
		hold_wd      = '0;
		case (state_q)
			ST_CLICK: begin
				if (tally_q != 2'd0 && unit_gt) begin
					push_en      = 1'b1;
					push_ev.kind = click_kind;
					push_ev.key  = click_key_q;
				end
			end
			ST_HOLD: begin
				if (hold_sel != '0) begin
					hold_we = 1'b1;
					hold_wd = unit_inc;
					if (unit_eq) begin
						push_en      = 1'b1;
						push_ev.kind = kdch_pkg::KIND_HOLDING;
					end
				end
			end
			ST_KEYS: begin
				if (diff_q[k_q]) begin
					if (hold_sel == '0 && !key_level) begin
						hold_we = 1'b1;
						hold_wd = COUNT_BITS'(1);
					end else if (key_level) begin
						hold_we = 1'b1;
						if (unit_gt) begin
							push_en      = 1'b1;
							push_ev.kind = kdch_pkg::KIND_RELEASED;
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign drain_next = EV_W'(drain_q) + EV_W'(1);
	assign drain_last = (drain_next == ev_cnt_q);
	assign out_load   = (state_q == ST_DRAIN) && (ev_cnt_q != '0) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			drain_q     <= '0;
			ev_cnt_q    <= '0;
			tick_q      <= '0;
			timer_q     <= '0;
			tally_q     <= '0;
			click_key_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				hold_q[i] <= '0;
			end
			any_held_q  <= 1'b0;
			change_q    <= 1'b0;
			prev_q      <= '1;
			rep_q       <= '1;
			thr_q       <= kdch_pkg::HOLD_THRESHOLD_RST;
			win_q       <= kdch_pkg::CLICK_WINDOW_RST;
			kiu_q       <= kdch_pkg::KEYS_IN_USE_RST;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_addr)
					kdch_pkg::REG_HOLD_THRESHOLD: thr_q <= cfg_data;
					kdch_pkg::REG_CLICK_WINDOW:   win_q <= cfg_data;
					kdch_pkg::REG_KEYS_IN_USE:    kiu_q <= cfg_data[1:0];
					default: ;
				endcase
			end

			if (push_en && ev_cnt_q < EV_W'(kdch_pkg::MAX_EVENTS)) begin
				ev_cnt_q <= ev_cnt_q + EV_W'(1);
			end

			if (hold_we) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (k_q == 2'(i)) begin
						hold_q[i] <= hold_wd;
					end
				end
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						change_q <= change_q | s_tuser;
						tick_q   <= tick_q + COUNT_BITS'(1);
						ev_cnt_q <= '0;
						state_q  <= ST_TIMER;
					end
				end
				ST_TIMER: begin
					timer_q <= unit_inc;
					state_q <= ST_CLICK;
				end
				ST_CLICK: begin
					if (push_en) begin
						timer_q <= '0;
						tally_q <= '0;
					end
					k_q     <= '0;
					state_q <= (any_held_q && scan != 2'd0) ? ST_HOLD : ST_CHANGE;
				end
				ST_HOLD: begin
					k_q <= k_next;
					if (k_last) begin
						state_q <= ST_CHANGE;
					end
				end
				ST_CHANGE: begin
					k_q     <= '0;
					drain_q <= '0;
					state_q <= ST_DRAIN;
					if (change_q) begin
						prev_q <= sample_q;
						if (prev_q == sample_q) begin
							change_q <= 1'b0;
							if (sample_q != rep_q) begin
								any_held_q <= 1'b0;
								rep_q      <= sample_q;
								if (scan != 2'd0) begin
									state_q <= ST_KEYS;
								end
							end
						end
					end
				end
				ST_KEYS: begin
					if (diff_q[k_q]) begin
						if (hold_sel == '0 && !key_level) begin
							any_held_q <= 1'b1;
						end else if (key_level && !unit_gt) begin
							// short press: count a click
							if (tally_q != kdch_pkg::TALLY_MAX) begin
								tally_q <= tally_q + 2'd1;
							end
							timer_q     <= '0;
							click_key_q <= k_q;
						end
					end else if (hold_sel != '0) begin
						any_held_q <= 1'b1;
					end
					k_q <= k_next;
					if (k_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (ev_cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else if (out_load) begin
						drain_q <= drain_next[1:0];
						if (drain_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			sample_q <= s_tdata[kdch_pkg::KEY_PINS-1:0];
		end
		if (state_q == ST_CHANGE) begin
			diff_q <= sample_q ^ rep_q;
		end
		if (push_en && ev_cnt_q < EV_W'(kdch_pkg::MAX_EVENTS)) begin
			ev_q[ev_cnt_q[1:0]] <= push_ev;
		end
		if (out_load) begin
			m_kind_q  <= ev_q[drain_q].kind;
			m_key_q   <= ev_q[drain_q].key;
			m_stamp_q <= tick_ext[kdch_pkg::STAMP_W-1:0];
			m_last_q  <= drain_last;
		end
	end

endmodule

>>> rtl/core/kdch_checker.sv
// Port-level checks of the key debounce detector, bound to its top level.
`include "key_debounce_click_hold_detector_defines.svh"

module kdch_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [kdch_pkg::M_TDATA_W-1:0]    m_tdata,
	input logic [kdch_pkg::KIND_W-1:0]       m_tuser,
	input logic                              m_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready
);

	// an accepted tick makes the block busy, and s_tready drops
	`KDCH_ASSERT_NXT(a_busy_after_tick, s_tvalid && s_tready, !s_tready, "ready right after a tick")

	`KDCH_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled item changed")

	`KDCH_ASSERT_IMP(a_kind_range, m_tvalid, m_tuser <= kdch_pkg::KIND_RELEASED, "event kind out of range")

	`KDCH_ASSERT_IMP(a_key_range, m_tvalid, (m_tdata[1:0] < 2'(kdch_pkg::KEY_PINS)) && (m_tdata[23:18] == 6'd0), "key index or padding bad")

endmodule

bind key_debounce_click_hold_detector kdch_checker u_kdch_checker (.*);
